/* sv/hpd_pkg.sv */
// ----------------------------------------------------------------------------
// hpd_pkg: shared types and constants of the hyperboloid patch dicer
// Fixed-point widths, CORDIC constants, reciprocal table and the control
// structs that pass between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package hpd_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_POINT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_POINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_ANGLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROW0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROW1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROW2  = 3'd5;

  localparam logic [15:0] SWEEP_RESET = 16'd51472;
  localparam logic [63:0] ROW0_RESET  = 64'h0000_0000_0000_0100;
  localparam logic [63:0] ROW1_RESET  = 64'h0000_0000_0100_0000;
  localparam logic [63:0] ROW2_RESET  = 64'h0000_0100_0000_0000;

  // Datapath widths.
  localparam int MUL_W = 34;   // multiplier operand
  localparam int ACC_W = 68;   // product and accumulator
  localparam int TH_W  = 36;   // angle, Q.30 radians
  localparam int CRD_W = 34;   // CORDIC x and y
  localparam int AT_W  = 5;    // arctangent table index

  localparam logic signed [TH_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [TH_W-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [TH_W-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [CRD_W-1:0] Q30_GAIN   = 34'sd652032874;

  localparam logic [30:0] ATAN_Q30 [24] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127
  };

  // ceil(2^19 / d) for a divisor d of 1 to 7; a divisor of zero gives zero,
  // so a grid side of one steps by nothing. Exact for dividends below 2^16.
  localparam int DIV_SHIFT = 19;
  localparam logic [19:0] RECIP_Q19 [8] = '{
    20'd0, 20'd524288, 20'd262144, 20'd174763,
    20'd131072, 20'd104858, 20'd87382, 20'd74899
  };

  typedef struct packed {
    logic en;
    logic load;
    logic neg;
  } mac_ctl_t;

  typedef struct packed {
    logic            start;
    logic [TH_W-1:0] theta;
  } crd_cmd_t;

  typedef struct packed {
    logic                    done;
    logic signed [CRD_W-1:0] cos_q;
    logic signed [CRD_W-1:0] sin_q;
  } crd_stat_t;

endpackage

`default_nettype wire

/* sv/hpd_if.sv */
// ----------------------------------------------------------------------------
// hpd_in_if / hpd_out_if: valid-ready channels of the patch dicer
// One interface for the dice requests and one for the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpd_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] u_start;
  logic [15:0] u_end;
  logic [15:0] v_start;
  logic [15:0] v_end;
  logic [3:0]  columns;
  logic [3:0]  rows;

  modport source(output valid, opcode, u_start, u_end, v_start, v_end, columns,
                 rows, input ready);
  modport sink(input valid, opcode, u_start, u_end, v_start, v_end, columns,
               rows, output ready);
endinterface

interface hpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [15:0]        s_coord;
  logic [15:0]        t_coord;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic               last;

  modport source(output valid, pos_x, pos_y, pos_z, s_coord, t_coord,
                 box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                 box_max_z, last, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, s_coord, t_coord,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
               box_max_z, last, output ready);
endinterface

`default_nettype wire

/* sv/hyperboloid_patch_dicer.sv */
// ----------------------------------------------------------------------------
// hyperboloid_patch_dicer: dices a hyperboloid patch into a grid of points
// A dice request gives u and v ranges and a grid size; the block emits one
// transformed vertex per grid point in row order, or one bounding box.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on in_ch and results leave on out_ch, both
// valid-ready channels; a transfer happens on a clock edge where valid and
// ready are both high. The user must write configuration through cfg_we,
// cfg_index and cfg_wdata while the block is idle; this is not enforced.
// Sequence. A request is taken only when the block is idle. After the accept,
// the S_DIVU and S_DIVV states set up the u and v steps; each vertex then
// passes through the angle product, the angle folding, one CORDIC step per
// cycle, a hand-over of the sine and cosine, sixteen passes through the one
// shared multiplier for the blend, the rotation and the 3x3 matrix, and the
// emit state. A bound request always walks GRID_MAX_SIDE squared vertices
// and then emits one box.
// Results sit in an output register. When the receiver stalls, the block
// waits on a vertex until the register is free; the final result of a
// request may still be waiting while the next request is accepted.
// Reset is synchronous: it empties the channels, returns the sequencer to
// idle and loads the register defaults (identity matrix, sweep of two pi).
// ----------------------------------------------------------------------------
`default_nettype none

module hyperboloid_patch_dicer import hpd_pkg::*; #(
  parameter int GRID_MAX_SIDE = 8,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hpd_in_if.sink                in_ch,
  hpd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = $clog2(GRID_MAX_SIDE + 1);

  // Sequencer states.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIVU  = 7'b0000010,
    S_DIVV  = 7'b0000100,
    S_THETA = 7'b0001000,
    S_CORD  = 7'b0010000,
    S_MAC   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  // Passes through the multiplier for one vertex.
  typedef enum logic [3:0] {
    MS_R0, MS_R1, MS_R2, MS_C0, MS_P0, MS_S0, MS_P1,
    MS_X0, MS_X1, MS_X2, MS_Y0, MS_Y1, MS_Y2, MS_Z0, MS_Z1, MS_Z2
  } mac_step_t;

  // Configuration registers. Matrix row three only feeds w, which is dropped.
  logic [47:0] p1_r, p2_r;
  logic [15:0] sweep_r;
  logic [63:0] mat_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r     <= '0;
      p2_r     <= '0;
      sweep_r  <= SWEEP_RESET;
      mat_r[0] <= ROW0_RESET;
      mat_r[1] <= ROW1_RESET;
      mat_r[2] <= ROW2_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_POINT:  p1_r     <= cfg_wdata[47:0];
        CFG_SECOND_POINT: p2_r     <= cfg_wdata[47:0];
        CFG_SWEEP_ANGLE:  sweep_r  <= cfg_wdata[15:0];
        CFG_MATRIX_ROW0:  mat_r[0] <= cfg_wdata;
        CFG_MATRIX_ROW1:  mat_r[1] <= cfg_wdata;
        CFG_MATRIX_ROW2:  mat_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Signed Q7.8 lanes of the generator points and matrix rows.
  logic signed [15:0] pa [3];
  logic signed [15:0] pb [3];
  logic signed [16:0] pd [3];
  logic signed [15:0] mk [3][4];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa[k] = p1_r[16*k +: 16];
      pb[k] = p2_r[16*k +: 16];
      pd[k] = {pb[k][15], pb[k]} - {pa[k][15], pa[k]};
      for (int c = 0; c < 4; c++) begin
        mk[k][c] = mat_r[k][16*c +: 16];
      end
    end
  end

  function automatic logic [15:0] clamp_param(input logic [15:0] x);
    return (x > 16'd32768) ? 16'd32768 : x;
  endfunction

  function automatic logic [SW-1:0] clamp_side(input logic [3:0] n);
    if (n == 4'd0) return SW'(1);
    if (32'(n) > GRID_MAX_SIDE) return SW'(GRID_MAX_SIDE);
    return SW'(n);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(64'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -ACC_W'(64'sh8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Request and walk state.
  state_t            state_r, state_nxt;
  mac_step_t         step_r;
  logic              op_r;
  logic [15:0]       u0_r, u1_r, v0_r, v1_r;
  logic [15:0]       du_r, dv_r;
  logic [15:0]       u_r, v_r;
  logic [SW-1:0]     cols_r, rows_r, i_r, j_r;

  logic signed [MUL_W-1:0] r_r [3];
  logic signed [MUL_W-1:0] p0_r, p1q_r, p2q_r;
  logic signed [31:0]      o_r [3];
  logic signed [31:0]      bmin_r [3];
  logic signed [31:0]      bmax_r [3];
  logic signed [31:0]      bmin_nxt [3];
  logic signed [31:0]      bmax_nxt [3];

  // Shared multiplier and CORDIC unit.
  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0] mac_add, acc_nxt;
  crd_cmd_t                crd_cmd;
  crd_stat_t               crd_stat;

  hpd_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .op_a    (mac_a),
    .op_b    (mac_b),
    .addend  (mac_add),
    .acc_nxt (acc_nxt)
  );

  hpd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (crd_cmd),
    .stat  (crd_stat)
  );

  // Operand selection for the multiplier.
  always_comb begin
    mac_ctl = '{en: 1'b0, load: 1'b1, neg: 1'b0};
    mac_a   = '0;
    mac_b   = '0;
    mac_add = '0;
    case (state_r)
      S_DIVU: begin
        mac_ctl.en = 1'b1;
        mac_a      = MUL_W'(u1_r - u0_r);
        mac_b      = MUL_W'(RECIP_Q19[3'(cols_r - SW'(1))]);
      end
      S_DIVV: begin
        mac_ctl.en = 1'b1;
        mac_a      = MUL_W'(v1_r - v0_r);
        mac_b      = MUL_W'(RECIP_Q19[3'(rows_r - SW'(1))]);
      end
      S_THETA: begin
        mac_ctl.en = 1'b1;
        mac_a      = MUL_W'(u_r);
        mac_b      = MUL_W'(sweep_r);
      end
      S_MAC: begin
        mac_ctl.en = 1'b1;
        case (step_r)
          MS_R0: begin
            mac_a = MUL_W'(pd[0]); mac_b = MUL_W'(v_r);
            mac_add = ACC_W'(pa[0]) <<< 15;
          end
          MS_R1: begin
            mac_a = MUL_W'(pd[1]); mac_b = MUL_W'(v_r);
            mac_add = ACC_W'(pa[1]) <<< 15;
          end
          MS_R2: begin
            mac_a = MUL_W'(pd[2]); mac_b = MUL_W'(v_r);
            mac_add = ACC_W'(pa[2]) <<< 15;
          end
          MS_C0: begin
            mac_a = r_r[0]; mac_b = crd_stat.cos_q;
          end
          MS_P0: begin
            mac_a = r_r[1]; mac_b = crd_stat.sin_q;
            mac_ctl.load = 1'b0; mac_ctl.neg = 1'b1;
          end
          MS_S0: begin
            mac_a = r_r[0]; mac_b = crd_stat.sin_q;
          end
          MS_P1: begin
            mac_a = r_r[1]; mac_b = crd_stat.cos_q;
            mac_ctl.load = 1'b0;
          end
          MS_X0: begin
            mac_a = MUL_W'(mk[0][0]); mac_b = p0_r;
            mac_add = ACC_W'(mk[0][3]) <<< 16;
          end
          MS_X1: begin
            mac_a = MUL_W'(mk[0][1]); mac_b = p1q_r; mac_ctl.load = 1'b0;
          end
          MS_X2: begin
            mac_a = MUL_W'(mk[0][2]); mac_b = p2q_r; mac_ctl.load = 1'b0;
          end
          MS_Y0: begin
            mac_a = MUL_W'(mk[1][0]); mac_b = p0_r;
            mac_add = ACC_W'(mk[1][3]) <<< 16;
          end
          MS_Y1: begin
            mac_a = MUL_W'(mk[1][1]); mac_b = p1q_r; mac_ctl.load = 1'b0;
          end
          MS_Y2: begin
            mac_a = MUL_W'(mk[1][2]); mac_b = p2q_r; mac_ctl.load = 1'b0;
          end
          MS_Z0: begin
            mac_a = MUL_W'(mk[2][0]); mac_b = p0_r;
            mac_add = ACC_W'(mk[2][3]) <<< 16;
          end
          MS_Z1: begin
            mac_a = MUL_W'(mk[2][1]); mac_b = p1q_r; mac_ctl.load = 1'b0;
          end
          MS_Z2: begin
            mac_a = MUL_W'(mk[2][2]); mac_b = p2q_r; mac_ctl.load = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // The angle u * sweep is Q.28; two more bits make it Q.30.
  assign crd_cmd.start = (state_r == S_THETA);
  assign crd_cmd.theta = {acc_nxt[TH_W-3:0], 2'b00};

  // Rounded shifts of the accumulator and of r_r[2]: half up, then floor.
  logic signed [ACC_W-1:0] rot_rnd, mat_rnd;
  logic signed [MUL_W-1:0] z_rnd;
  assign rot_rnd = (acc_nxt + (ACC_W'(1) <<< 36)) >>> 37;
  assign mat_rnd = (acc_nxt + ACC_W'(128)) >>> 8;
  assign z_rnd   = (r_r[2] + MUL_W'(64)) >>> 7;

  // Walk position.
  logic        first_v, last_col, last_v, need_slot, slot_free, go;
  logic [16:0] u_sum, v_sum;

  assign first_v   = (i_r == '0) && (j_r == '0);
  assign last_col  = (i_r == cols_r - SW'(1));
  assign last_v    = last_col && (j_r == rows_r - SW'(1));
  assign need_slot = !op_r || last_v;
  assign slot_free = !out_ch.valid || out_ch.ready;
  assign go        = (state_r == S_EMIT) && (!need_slot || slot_free);
  assign u_sum     = {1'b0, u_r} + {1'b0, du_r};
  assign v_sum     = {1'b0, v_r} + {1'b0, dv_r};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      bmin_nxt[k] = (first_v || o_r[k] < bmin_r[k]) ? o_r[k] : bmin_r[k];
      bmax_nxt[k] = (first_v || o_r[k] > bmax_r[k]) ? o_r[k] : bmax_r[k];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_DIVU;
      S_DIVU:  state_nxt = S_DIVV;
      S_DIVV:  state_nxt = S_THETA;
      S_THETA: state_nxt = S_CORD;
      S_CORD:  if (crd_stat.done) state_nxt = S_MAC;
      S_MAC:   if (step_r == MS_Z2) state_nxt = S_EMIT;
      S_EMIT:  if (go) state_nxt = last_v ? S_IDLE : S_THETA;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [15:0] us_clamp, ue_clamp, vs_clamp, ve_clamp;
  assign us_clamp = clamp_param(in_ch.u_start);
  assign ue_clamp = clamp_param(in_ch.u_end);
  assign vs_clamp = clamp_param(in_ch.v_start);
  assign ve_clamp = clamp_param(in_ch.v_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= MS_R0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_MAC) step_r <= mac_step_t'(step_r + 4'd1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r   <= in_ch.opcode;
        u0_r   <= us_clamp;
        u_r    <= us_clamp;
        u1_r   <= (ue_clamp < us_clamp) ? us_clamp : ue_clamp;
        v0_r   <= vs_clamp;
        v_r    <= vs_clamp;
        v1_r   <= (ve_clamp < vs_clamp) ? vs_clamp : ve_clamp;
        cols_r <= in_ch.opcode ? SW'(GRID_MAX_SIDE) : clamp_side(in_ch.columns);
        rows_r <= in_ch.opcode ? SW'(GRID_MAX_SIDE) : clamp_side(in_ch.rows);
        i_r    <= '0;
        j_r    <= '0;
      end
      S_DIVU: du_r <= acc_nxt[DIV_SHIFT +: 16];
      S_DIVV: dv_r <= acc_nxt[DIV_SHIFT +: 16];
      S_MAC: begin
        case (step_r)
          MS_R0: r_r[0] <= MUL_W'(acc_nxt);
          MS_R1: r_r[1] <= MUL_W'(acc_nxt);
          MS_R2: r_r[2] <= MUL_W'(acc_nxt);
          MS_P0: p0_r   <= MUL_W'(rot_rnd);
          MS_P1: begin
            p1q_r <= MUL_W'(rot_rnd);
            p2q_r <= z_rnd;
          end
          MS_X2: o_r[0] <= sat32(mat_rnd);
          MS_Y2: o_r[1] <= sat32(mat_rnd);
          MS_Z2: o_r[2] <= sat32(mat_rnd);
          default: ;
        endcase
      end
      S_EMIT: begin
        if (go) begin
          bmin_r <= bmin_nxt;
          bmax_r <= bmax_nxt;
          if (last_col) begin
            i_r <= '0;
            j_r <= j_r + SW'(1);
            u_r <= u0_r;
            v_r <= (v_sum < {1'b0, v1_r}) ? v_sum[15:0] : v1_r;
          end else begin
            i_r <= i_r + SW'(1);
            u_r <= (u_sum < {1'b0, u1_r}) ? u_sum[15:0] : u1_r;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register.
  logic               ov_r;
  logic signed [31:0] opos_r [3];
  logic signed [31:0] omin_r [3];
  logic signed [31:0] omax_r [3];
  logic [15:0]        os_r, ot_r;
  logic               olast_r;
  logic               load_out;

  assign load_out = go && need_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_out) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
    if (load_out) begin
      olast_r <= last_v;
      for (int k = 0; k < 3; k++) begin
        opos_r[k] <= op_r ? '0 : o_r[k];
        omin_r[k] <= op_r ? bmin_nxt[k] : '0;
        omax_r[k] <= op_r ? bmax_nxt[k] : '0;
      end
      os_r <= op_r ? '0 : u_r;
      ot_r <= op_r ? '0 : v_r;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.pos_x     = opos_r[0];
  assign out_ch.pos_y     = opos_r[1];
  assign out_ch.pos_z     = opos_r[2];
  assign out_ch.s_coord   = os_r;
  assign out_ch.t_coord   = ot_r;
  assign out_ch.box_min_x = omin_r[0];
  assign out_ch.box_min_y = omin_r[1];
  assign out_ch.box_min_z = omin_r[2];
  assign out_ch.box_max_x = omax_r[0];
  assign out_ch.box_max_y = omax_r[1];
  assign out_ch.box_max_z = omax_r[2];
  assign out_ch.last      = olast_r;

endmodule

`default_nettype wire

/* sv/hpd_mac.sv */
// ----------------------------------------------------------------------------
// hpd_mac: shared multiply-accumulate unit
// One signed multiplier whose product is added to or subtracted from either
// a loaded addend or the running accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_mac import hpd_pkg::*; (
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  input  logic signed [MUL_W-1:0] op_a,
  input  logic signed [MUL_W-1:0] op_b,
  input  logic signed [ACC_W-1:0] addend,
  output logic signed [ACC_W-1:0] acc_nxt
);

  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] base;

  assign prod    = op_a * op_b;
  assign base    = ctl.load ? addend : acc_r;
  assign acc_nxt = ctl.neg ? base - prod : base + prod;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/hpd_cordic.sv */
// ----------------------------------------------------------------------------
// hpd_cordic: iterative sine and cosine unit
// Reduces the angle to the right half plane in three steps, then runs one
// shift-add rotation step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_cordic import hpd_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  crd_cmd_t  cmd,
  output crd_stat_t stat
);

  localparam int CW = $clog2(STEPS + 4);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic                    flip_r, flip_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic signed [TH_W-1:0]  th_r, th_nxt;
  logic signed [CRD_W-1:0] x_r, x_nxt;
  logic signed [CRD_W-1:0] y_r, y_nxt;
  logic [CW-1:0]           it;
  logic [AT_W-1:0]         idx;
  logic signed [TH_W-1:0]  atan;
  logic signed [CRD_W-1:0] sx, sy;

  assign it   = cnt_r - CW'(3);
  assign idx  = AT_W'(it);
  assign atan = signed'({{(TH_W-31){1'b0}}, ATAN_Q30[idx]});
  assign sx   = x_r >>> idx;
  assign sy   = y_r >>> idx;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    flip_nxt = flip_r;
    cnt_nxt  = cnt_r;
    th_nxt   = th_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      flip_nxt = 1'b0;
      cnt_nxt  = '0;
      th_nxt   = signed'(cmd.theta);
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(0)) begin
        if (th_r >= Q30_TWO_PI) th_nxt = th_r - Q30_TWO_PI;
      end else if (cnt_r == CW'(1)) begin
        if (th_r > Q30_PI) th_nxt = th_r - Q30_TWO_PI;
      end else if (cnt_r == CW'(2)) begin
        // Fold the angle into [-pi/2, pi/2] and, when it folds, flip the result sign.
        x_nxt = Q30_GAIN;
        y_nxt = '0;
        if (th_r > Q30_HALF_PI) begin
          th_nxt   = th_r - Q30_PI;
          flip_nxt = 1'b1;
        end else if (th_r < -Q30_HALF_PI) begin
          th_nxt   = th_r + Q30_PI;
          flip_nxt = 1'b1;
        end
      end else begin
        if (!th_r[TH_W-1]) begin
          x_nxt  = x_r - sy;
          y_nxt  = y_r + sx;
          th_nxt = th_r - atan;
        end else begin
          x_nxt  = x_r + sy;
          y_nxt  = y_r - sx;
          th_nxt = th_r + atan;
        end
        if (it == CW'(STEPS - 1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    flip_r <= flip_nxt;
    th_r   <= th_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
  end

  assign stat.done  = done_r;
  assign stat.cos_q = flip_r ? -x_r : x_r;
  assign stat.sin_q = flip_r ? -y_r : y_r;

endmodule

`default_nettype wire

/* sv/hpd_checker.sv */
// ----------------------------------------------------------------------------
// hpd_checker: port-level checks of the patch dicer
// Watches the two channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_box_min_x
);

  // A stalled result keeps its x position, its x box minimum and its last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x)
                                 && $stable(out_box_min_x) && $stable(out_last))
    else $error("stalled result changed");

  // Once a request is taken the block is busy for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // When idle, only the final result of a request can still be waiting.
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("idle with a non-final result pending");

  // Reset leaves the result channel empty.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hyperboloid_patch_dicer hpd_checker u_hpd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_last      (out_ch.last),
  .out_pos_x     (out_ch.pos_x),
  .out_box_min_x (out_ch.box_min_x)
);

`default_nettype wire
